// File: hw/rtl/hps_pkg.sv
// types and constants shared by the host power sequencer
`default_nettype none

package hps_pkg;

  localparam int unsigned RegWidth    = 16;
  localparam int unsigned CfgIdxWidth = 3;

  localparam logic [RegWidth-1:0] ConfirmWindowRst    = 16'd10000;
  localparam logic [RegWidth-1:0] StartupWindowRst    = 16'd5000;
  localparam logic [RegWidth-1:0] ShutdownPulseLenRst = 16'd200;
  localparam logic [RegWidth-1:0] WakePulseLenRst     = 16'd50;
  localparam logic [RegWidth-1:0] FlashHalfPeriodRst  = 16'd50;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_CONFIRM_WINDOW     = 3'd0,
    CFG_STARTUP_WINDOW     = 3'd1,
    CFG_SHUTDOWN_PULSE_LEN = 3'd2,
    CFG_WAKE_PULSE_LEN     = 3'd3,
    CFG_FLASH_HALF_PERIOD  = 3'd4
  } cfg_idx_e;

  // internal one-hot mode encoding
  typedef enum logic [6:0] {
    MODE_OFF     = 7'b000_0001,
    MODE_WAKE    = 7'b000_0010,
    MODE_START   = 7'b000_0100,
    MODE_ON      = 7'b000_1000,
    MODE_CONFIRM = 7'b001_0000,
    MODE_SDPULSE = 7'b010_0000,
    MODE_SDWAIT  = 7'b100_0000
  } mode_e;

  // mode as reported on the result item
  typedef enum logic [2:0] {
    MCODE_OFF     = 3'd0,
    MCODE_WAKE    = 3'd1,
    MCODE_START   = 3'd2,
    MCODE_ON      = 3'd3,
    MCODE_CONFIRM = 3'd4,
    MCODE_SDPULSE = 3'd5,
    MCODE_SDWAIT  = 3'd6
  } mode_code_e;

  typedef enum logic [1:0] {
    COLOR_DARK   = 2'd0,
    COLOR_RED    = 2'd1,
    COLOR_YELLOW = 2'd2,
    COLOR_GREEN  = 2'd3
  } color_e;

  typedef enum logic [2:0] {
    OUTCOME_NONE         = 3'd0,
    OUTCOME_STARTED      = 3'd1,
    OUTCOME_START_FAILED = 3'd2,
    OUTCOME_SHUT_DOWN    = 3'd3,
    OUTCOME_NO_SHUTDOWN  = 3'd4
  } outcome_e;

  typedef struct packed {
    logic button_pushed;
    logic host_detect;
  } in_item_t;

  typedef struct packed {
    logic       line_low;
    logic [1:0] led_color;
    logic [2:0] mode_code;
    logic [2:0] outcome;
  } out_item_t;

  typedef struct packed {
    logic [RegWidth-1:0] confirm_window;
    logic [RegWidth-1:0] startup_window;
    logic [RegWidth-1:0] shutdown_pulse_len;
    logic [RegWidth-1:0] wake_pulse_len;
    logic [RegWidth-1:0] flash_half_period;
  } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/hps_in_stage.sv
// input register stage holding one accepted tick item
`default_nettype none

module hps_in_stage
  import hps_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  input  wire logic     take_i,
  output logic          stage_valid_o,
  output in_item_t      stage_item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign stage_valid_o = valid_q;
  assign stage_item_o  = item_q;

endmodule

`default_nettype wire

// File: hw/rtl/hps_core.sv
// sequencer state, timers and per-tick next-state and result logic
`default_nettype none

module hps_core
  import hps_pkg::*;
#(
  parameter int unsigned TimerBits = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire in_item_t item_i,
  input  wire cfg_t     cfg_i,
  output out_item_t     result_o
);

  localparam int unsigned CmpW = (TimerBits > RegWidth) ? TimerBits : RegWidth;
  localparam logic [TimerBits-1:0] TimerMax = '1;

  function automatic logic [TimerBits-1:0] bump(input logic [TimerBits-1:0] t);
    return (t == TimerMax) ? t : t + TimerBits'(1);
  endfunction

  function automatic logic reached(input logic [TimerBits-1:0] t,
                                   input logic [RegWidth-1:0]  lim);
    return CmpW'(t) >= CmpW'(lim);
  endfunction

  function automatic logic flashing(input mode_e m);
    return (m == MODE_WAKE) || (m == MODE_START) || (m == MODE_CONFIRM) ||
           (m == MODE_SDPULSE) || (m == MODE_SDWAIT);
  endfunction

  function automatic mode_code_e code_of(input mode_e m);
    mode_code_e c;
    case (m)
      MODE_WAKE:    c = MCODE_WAKE;
      MODE_START:   c = MCODE_START;
      MODE_ON:      c = MCODE_ON;
      MODE_CONFIRM: c = MCODE_CONFIRM;
      MODE_SDPULSE: c = MCODE_SDPULSE;
      MODE_SDWAIT:  c = MCODE_SDWAIT;
      default:      c = MCODE_OFF;
    endcase
    return c;
  endfunction

  mode_e                mode_q, mode_d;
  logic [TimerBits-1:0] win_q, win_d;
  logic [TimerBits-1:0] flash_q, flash_d;
  logic                 phase_q, phase_d;
  color_e               held_q, held_d;
  logic                 started_q, started_d;
  outcome_e             outcome;
  logic [TimerBits-1:0] win_inc;
  logic [TimerBits-1:0] flash_inc;
  logic                 push, det;

  assign push      = item_i.button_pushed;
  assign det       = item_i.host_detect;
  assign win_inc   = bump(win_q);
  assign flash_inc = bump(flash_q);

  always_comb begin
    mode_d    = mode_q;
    win_d     = win_q;
    flash_d   = flash_q;
    phase_d   = phase_q;
    held_d    = held_q;
    started_d = 1'b1;
    outcome   = OUTCOME_NONE;

    if (!started_q) begin
      // first tick only samples detect, a push is dropped
      mode_d = det ? MODE_ON : MODE_OFF;
      held_d = det ? COLOR_GREEN : COLOR_RED;
      win_d  = '0;
    end else begin
      case (mode_q)
        MODE_WAKE: begin
          win_d = win_inc;
          if (reached(win_inc, cfg_i.wake_pulse_len)) begin
            mode_d = MODE_START;
            win_d  = '0;
          end
        end
        MODE_START: begin
          if (det) begin
            mode_d  = MODE_ON;
            win_d   = '0;
            held_d  = COLOR_GREEN;
            outcome = OUTCOME_STARTED;
          end else begin
            win_d = win_inc;
            if (reached(win_inc, cfg_i.startup_window)) begin
              mode_d  = MODE_OFF;
              win_d   = '0;
              held_d  = COLOR_RED;
              outcome = OUTCOME_START_FAILED;
            end
          end
        end
        MODE_ON: begin
          if (push) begin
            mode_d = MODE_CONFIRM;
            win_d  = '0;
          end else begin
            mode_d = det ? MODE_ON : MODE_OFF;
          end
        end
        MODE_CONFIRM: begin
          if (push) begin
            mode_d = MODE_SDPULSE;
            win_d  = '0;
          end else begin
            win_d = win_inc;
            if (reached(win_inc, cfg_i.confirm_window)) begin
              mode_d  = MODE_ON;
              win_d   = '0;
              held_d  = COLOR_GREEN;
              outcome = OUTCOME_NO_SHUTDOWN;
            end
          end
        end
        MODE_SDPULSE: begin
          win_d = win_inc;
          if (reached(win_inc, cfg_i.shutdown_pulse_len)) begin
            mode_d = MODE_SDWAIT;
            win_d  = '0;
          end
        end
        MODE_SDWAIT: begin
          if (!det) begin
            mode_d  = MODE_OFF;
            win_d   = '0;
            held_d  = COLOR_RED;
            outcome = OUTCOME_SHUT_DOWN;
          end else begin
            win_d = win_inc;
            if (reached(win_inc, cfg_i.confirm_window)) begin
              mode_d  = MODE_ON;
              win_d   = '0;
              held_d  = COLOR_GREEN;
              outcome = OUTCOME_NO_SHUTDOWN;
            end
          end
        end
        default: begin
          // off
          if (push) begin
            mode_d = MODE_WAKE;
            win_d  = '0;
          end else begin
            mode_d = det ? MODE_ON : MODE_OFF;
          end
        end
      endcase
    end

    // flasher restarts dark when a waiting mode is entered
    if (flashing(mode_d)) begin
      if (!flashing(mode_q)) begin
        flash_d = '0;
        phase_d = 1'b0;
      end else begin
        flash_d = flash_inc;
        if (reached(flash_inc, cfg_i.flash_half_period)) begin
          flash_d = '0;
          phase_d = !phase_q;
        end
      end
    end
  end

  always_comb begin
    result_o.line_low  = (mode_d == MODE_WAKE) || (mode_d == MODE_SDPULSE);
    result_o.led_color = flashing(mode_d) ? (phase_d ? COLOR_YELLOW : COLOR_DARK) : held_d;
    result_o.mode_code = code_of(mode_d);
    result_o.outcome   = outcome;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_OFF;
      win_q     <= '0;
      flash_q   <= '0;
      phase_q   <= 1'b0;
      held_q    <= COLOR_RED;
      started_q <= 1'b0;
    end else if (step_i) begin
      mode_q    <= mode_d;
      win_q     <= win_d;
      flash_q   <= flash_d;
      phase_q   <= phase_d;
      held_q    <= held_d;
      started_q <= started_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/host_power_sequencer.sv
// top level of the host power sequencer: config registers, pipeline and result register
`default_nettype none

// Host power sequencer. Each input item is one millisecond tick with a debounced
// button push and the host power-detect level; each item yields exactly one result
// item with the shutdown/wake line drive, indicator color, mode code and outcome.
// The block takes one item per clock cycle unless output backpressure stalls it: the
// item sits in an input register, the sequencer logic computes the next state and the
// result in a single pass, and the result is loaded into an output register. The
// result is valid once the item has passed the input register and then the output
// register; a stall on the output side holds it back. The output register and input
// register decouple the two sides, so a new item is taken while a finished result still
// waits; under output backpressure at most two items are held in flight.
// Configuration writes are always accepted (cfg_ready_o is tied high) and take effect
// on the next tick; indexes beyond the register list are ignored. Timers are
// TIMER_BITS wide and saturate, so a window longer than the timer range never expires.
// After reset the first tick only samples host detect to choose on or off.

module host_power_sequencer
  import hps_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // tick items
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire in_item_t               in_item_i,
  // result items
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output out_item_t                   out_item_o,
  // configuration writes
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [RegWidth-1:0]    cfg_data_i
);

  // ------------------------------------------------------------ config registers
  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CONFIRM_WINDOW:     cfg_d.confirm_window     = cfg_data_i;
        CFG_STARTUP_WINDOW:     cfg_d.startup_window     = cfg_data_i;
        CFG_SHUTDOWN_PULSE_LEN: cfg_d.shutdown_pulse_len = cfg_data_i;
        CFG_WAKE_PULSE_LEN:     cfg_d.wake_pulse_len     = cfg_data_i;
        CFG_FLASH_HALF_PERIOD:  cfg_d.flash_half_period  = cfg_data_i;
        default:                cfg_d = cfg_q;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.confirm_window     <= ConfirmWindowRst;
      cfg_q.startup_window     <= StartupWindowRst;
      cfg_q.shutdown_pulse_len <= ShutdownPulseLenRst;
      cfg_q.wake_pulse_len     <= WakePulseLenRst;
      cfg_q.flash_half_period  <= FlashHalfPeriodRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ------------------------------------------------------------ input stage
  logic      stage_valid;
  in_item_t  stage_item;
  logic      take;
  out_item_t result;

  // the staged item moves on when the output register is free or draining
  assign take = stage_valid && (!out_valid_o || out_ready_i);

  hps_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_item_i     (in_item_i),
    .take_i        (take),
    .stage_valid_o (stage_valid),
    .stage_item_o  (stage_item)
  );

  // ------------------------------------------------------------ sequencer
  hps_core #(
    .TimerBits (TIMER_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (take),
    .item_i   (stage_item),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  // ------------------------------------------------------------ result register
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // ------------------------------------------------------------ assertions
  // line is pulled low exactly in the two pulse modes
  a_line_low_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.line_low ==
                     ((out_item_o.mode_code == MCODE_WAKE) ||
                      (out_item_o.mode_code == MCODE_SDPULSE))))
    else $error("line drive does not match mode");

  // every outcome event lands in an idle mode
  a_outcome_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.outcome != OUTCOME_NONE)) |->
      ((out_item_o.mode_code == MCODE_ON) || (out_item_o.mode_code == MCODE_OFF)))
    else $error("outcome reported outside an idle mode");

  // idle modes show a steady red or green
  a_idle_color : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((out_item_o.mode_code == MCODE_ON) ||
                     (out_item_o.mode_code == MCODE_OFF))) |->
      ((out_item_o.led_color == COLOR_RED) || (out_item_o.led_color == COLOR_GREEN)))
    else $error("idle mode shows a flashing color");

  // a result is produced in the cycle after the staged item is taken
  a_take_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_o)
    else $error("taken item produced no result");

endmodule

`default_nettype wire
